/* rtl/core/pidl_pkg.sv */
// Shared types, widths and codes for the positional insert/delete list.
package pidl_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned POS_W     = 8;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned CAP_W     = 5;
    localparam int unsigned CNT_OUT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Shift command broadcast to every cell; idx is the 0-based slot.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] idx;
    } shift_op_t;

    // Result fields produced by the controller for the accepted word.
    typedef struct packed {
        status_t              status;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
        logic                 full;
    } result_t;

endpackage

/* rtl/core/pidl_cell.sv */
// One storage cell of the list: holds an entry and shifts with its neighbors.
module pidl_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                          aclk,
    input  pidl_pkg::shift_op_t           op,
    input  logic [pidl_pkg::DATA_W-1:0]   ins_value,
    input  logic [pidl_pkg::DATA_W-1:0]   left_data,
    input  logic [pidl_pkg::DATA_W-1:0]   right_data,
    output logic [pidl_pkg::DATA_W-1:0]   data
);
    import pidl_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [DATA_W-1:0] data_reg;

    // Insert: take the new value at the slot, move up above it.
    // Remove: pull down from the right at and above the slot.
    always_ff @(posedge aclk) begin
        if (op.ins && (MY_IDX >= op.idx)) begin
            data_reg <= (MY_IDX == op.idx) ? ins_value : left_data;
        end else if (op.del && (MY_IDX >= op.idx)) begin
            data_reg <= right_data;
        end
    end

    assign data = data_reg;

endmodule

/* rtl/core/pidl_ctrl.sv */
// List controller: command decode, range checks and the entry count.
module pidl_ctrl #(
    parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [pidl_pkg::CMD_W-1:0]    cmd,
    input  logic [pidl_pkg::POS_W-1:0]    position,
    input  logic [pidl_pkg::CAP_W-1:0]    capacity,
    output pidl_pkg::shift_op_t           op,
    output pidl_pkg::result_t             result,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import pidl_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int unsigned LIM_W = ((CMP_W > CAP_W) ? CMP_W : CAP_W);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_new;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [LIM_W-1:0] limit;
    logic             full_now;
    status_t          status;
    logic             do_ins;
    logic             do_del;
    logic [POS_W-1:0] idx;

    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(position);
    assign limit   = (LIM_W'(capacity) < LIM_W'(DEPTH)) ? LIM_W'(capacity) : LIM_W'(DEPTH);
    assign full_now = LIM_W'(count_reg) >= limit;

    always_comb begin
        status    = ST_OK;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        idx       = position - POS_W'(1);
        count_new = count_reg;
        case (cmd_t'(cmd))
            CMD_APPEND: begin
                if (full_now) begin
                    status = ST_FULL;
                end else begin
                    do_ins    = 1'b1;
                    idx       = POS_W'(count_reg);
                    count_new = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (full_now) begin
                    status = ST_FULL;
                end else if ((position == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
                    status = ST_BADPOS;
                end else begin
                    do_ins    = 1'b1;
                    count_new = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else if ((position == '0) || (pos_ext > cnt_ext)) begin
                    status = ST_BADPOS;
                end else begin
                    do_del    = 1'b1;
                    count_new = count_reg - CNT_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign count_next = accept ? count_new : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign op.ins = accept & do_ins;
    assign op.del = accept & do_del;
    assign op.idx = idx;

    assign result.status = status;
    assign result.count  = CNT_OUT_W'(count_new);
    assign result.empty  = (count_new == '0);
    assign result.full   = LIM_W'(count_new) >= limit;

    assign count = count_reg;

endmodule

/* rtl/core/positional_insert_delete_list_top.sv */
// A result word appears in m_* in the cycle after its command word is accepted.
// One word per cycle unless the output stalls; every cell shifts in the same cycle.
// s_ready stays high while the output register is empty or being drained.
// Reset clears the entry count, the output valid and sets capacity to 16.
// Cell contents are not reset; only entries below the count are ever read.
module positional_insert_delete_list_top #(
    parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [pidl_pkg::CAP_W-1:0]      cfg_wr_data,
    // command channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pidl_pkg::CMD_W-1:0]      s_cmd,
    input  logic [pidl_pkg::POS_W-1:0]      s_position,
    input  logic signed [pidl_pkg::DATA_W-1:0] s_value,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pidl_pkg::STAT_W-1:0]     m_status,
    output logic signed [pidl_pkg::DATA_W-1:0] m_removed_value,
    output logic [pidl_pkg::CNT_OUT_W-1:0]  m_entry_count,
    output logic                            m_is_empty_flag,
    output logic                            m_is_full_flag
);
    import pidl_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Capacity reg: the user writes it only while the list is idle; not enforced.
    logic [CAP_W-1:0] capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RST;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Accept a new word whenever the output register is free or draining.
    logic accept;
    logic m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Controller: decide the shift and the result fields for this word.
    shift_op_t        op;
    result_t          result;
    logic [CNT_W-1:0] count;

    pidl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .cmd      (s_cmd),
        .position (s_position),
        .capacity (capacity_reg),
        .op       (op),
        .result   (result),
        .count    (count)
    );

    // Chain of cells. Each cell sees its left and right neighbor, so an
    // insert moves the tail up and a remove pulls it down, all cells at once.
    logic [DATA_W-1:0] cell_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        pidl_cell #(
            .INDEX (g)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .ins_value  (s_value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g])
        );
    end

    // Pick the outgoing entry before the cells shift; zero unless removing.
    logic [DATA_W-1:0] removed;

    assign removed = op.del ? cell_data[op.idx[IDX_W-1:0]] : '0;

    // Output register: load on accept, drop valid when taken with nothing new.
    logic [STAT_W-1:0]    status_reg;
    logic [DATA_W-1:0]    removed_reg;
    logic [CNT_OUT_W-1:0] count_out_reg;
    logic                 empty_reg;
    logic                 full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= result.status;
            removed_reg   <= removed;
            count_out_reg <= result.count;
            empty_reg     <= result.empty;
            full_reg      <= result.full;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;
    assign m_entry_count   = count_out_reg;
    assign m_is_empty_flag = empty_reg;
    assign m_is_full_flag  = full_reg;

`ifndef SYNTHESIS
    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(count) <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // A shift is either an insert or a remove, never both.
    a_op_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(op.ins && op.del))
        else $error("insert and remove in the same cycle");

    // A successful remove lowers the count by exactly one.
    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        op.del |=> (count == $past(count) - CNT_W'(1)))
        else $error("remove did not decrement count");

    // Only an ok status may carry a removed value.
    a_removed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_removed_value == '0))
        else $error("removed value on a failed command");
`endif

endmodule
